// ----- hdl/emst_pkg.sv -----
package emst_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int TOTAL_BITS = 41;
    localparam int USED_BITS  = 9;

    // squared distance, radicand and root widths
    localparam int D2_BITS   = 2 * COORD_BITS + 1;
    localparam int RAD_RAW   = D2_BITS + 2 * FRAC_BITS;
    localparam int RAD_BITS  = RAD_RAW + (RAD_RAW % 2);
    localparam int ROOT_BITS = RAD_BITS / 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         last_point;
    } in_word_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] total_length;
        logic [USED_BITS-1:0]  points_used;
        logic                  points_dropped;
    } out_word_t;

    typedef struct packed {
        logic                         valid;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } point_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // one sweep down the chain: newest tree point plus running minimum
    typedef struct packed {
        logic                         valid;
        logic                         first;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic                         found;
        logic [D2_BITS-1:0]           dmin;
        logic signed [COORD_BITS-1:0] mx;
        logic signed [COORD_BITS-1:0] my;
    } wave_t;

endpackage

// ----- hdl/emst_cell.sv -----
module emst_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  emst_pkg::cell_ctrl_t ctrl,
    input  emst_pkg::point_t   pt_in,
    output emst_pkg::point_t   pt_out,
    input  emst_pkg::wave_t    wave_in,
    output emst_pkg::wave_t    wave_out
);
    import emst_pkg::*;

    logic                         valid_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic                         in_tree_reg;
    logic                         in_tree_next;
    logic [D2_BITS-1:0]           dist_reg;
    logic [D2_BITS-1:0]           dist_next;
    wave_t                        wave_reg;
    wave_t                        wave_next;

    logic                         match;
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic [COORD_BITS-1:0]        ax;
    logic [COORD_BITS-1:0]        ay;
    logic [D2_BITS-1:0]           d2;
    logic                         active;

    assign pt_out   = '{valid: valid_reg, x: x_reg, y: y_reg};
    assign wave_out = wave_reg;

    assign active = wave_in.valid && valid_reg;
    assign match  = (x_reg == wave_in.bx) && (y_reg == wave_in.by);
    assign dx     = {x_reg[COORD_BITS-1], x_reg} - {wave_in.bx[COORD_BITS-1], wave_in.bx};
    assign dy     = {y_reg[COORD_BITS-1], y_reg} - {wave_in.by[COORD_BITS-1], wave_in.by};
    assign ax     = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    assign ay     = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    assign d2     = D2_BITS'(ax * ax) + D2_BITS'(ay * ay);

    always_comb
    begin
        in_tree_next = in_tree_reg;
        dist_next    = dist_reg;
        wave_next    = wave_in;
        if (active)
        begin
            in_tree_next = wave_in.first ? match : (in_tree_reg | match);
            if (!in_tree_next)
            begin
                dist_next = (wave_in.first || d2 < dist_reg) ? d2 : dist_reg;
                if (!wave_in.found || dist_next < wave_in.dmin)
                begin
                    wave_next.found = 1'b1;
                    wave_next.dmin  = dist_next;
                    wave_next.mx    = x_reg;
                    wave_next.my    = y_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            in_tree_reg <= 1'b0;
            wave_reg    <= '0;
        end
        else
        begin
            if (ctrl.clear)
                valid_reg <= 1'b0;
            else if (ctrl.shift)
                valid_reg <= pt_in.valid;
            in_tree_reg <= in_tree_next;
            wave_reg    <= wave_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            x_reg <= pt_in.x;
            y_reg <= pt_in.y;
        end
        dist_reg <= dist_next;
    end

endmodule

// ----- hdl/emst_root.sv -----
module emst_root (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [emst_pkg::D2_BITS-1:0]  d2,
    output logic                          done,
    output logic                          busy,
    output logic [emst_pkg::ROOT_BITS-1:0] root
);
    import emst_pkg::*;

    localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

    logic [RAD_BITS-1:0]    rad_reg;
    logic [ROOT_BITS+1:0]   rem_reg;
    logic [ROOT_BITS-1:0]   root_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [ROOT_BITS+1:0]   rem_sh;
    logic [ROOT_BITS+1:0]   trial;
    logic                   take;

    assign rem_sh = {rem_reg[ROOT_BITS-1:0], rad_reg[RAD_BITS-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign take   = rem_sh >= trial;
    assign done   = done_reg;
    assign busy   = busy_reg;
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(ROOT_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one root bit per cycle, restoring
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rad_reg  <= {{(RAD_BITS - RAD_RAW){1'b0}}, d2, {(2 * FRAC_BITS){1'b0}}};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_BITS-2:0], take};
        end
    end

    done_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg))
        else $error("root done without a running root");
    no_go_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !go)
        else $error("root restarted while running");
    done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("root done held");

endmodule

// ----- hdl/euclidean_mst_total_length.sv -----
// Euclidean minimum spanning tree length.
// Input channel: in_word carries one point (point_x, point_y, last_point).
// A word is taken on a rising edge with start high and busy low, one point
// per cycle while loading. Points land in a chain of MAX_POINTS cells; once
// the chain is full further points are dropped and flagged.
// The word with last_point set (stored if room remains) starts the tree
// build, and busy stays high until the result has gone out.
// Build: Prim's method over squared distances, which picks the same tree.
// Each step sends one sweep down the cell chain, each cell folding the
// newest tree point into its own nearest distance and into the running
// minimum. The winning squared distance then goes through a bit-serial
// root unit and into the total. Result: result_valid pulses for exactly
// one cycle with result; the receiver cannot stall. The chain is emptied
// after each result. Reset empties the chain and returns to idle.
module euclidean_mst_total_length #(
    parameter int MAX_POINTS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  emst_pkg::in_word_t  in_word,
    output logic                result_valid,
    output emst_pkg::out_word_t result
);
    import emst_pkg::*;

    localparam int CNT_BITS = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_WAVE, ST_ROOT, ST_DONE} state_t;

    state_t                       state_reg;
    logic [CNT_BITS-1:0]          n_reg;
    logic                         ovf_reg;
    logic                         launch_reg;
    logic                         first_reg;
    logic signed [COORD_BITS-1:0] bx_reg;
    logic signed [COORD_BITS-1:0] by_reg;
    logic signed [COORD_BITS-1:0] lx_reg;
    logic signed [COORD_BITS-1:0] ly_reg;
    logic [TOTAL_BITS-1:0]        acc_reg;
    logic                         go_reg;
    logic [D2_BITS-1:0]           d2_reg;
    out_word_t                    result_reg;

    logic                         accept;
    logic                         room;
    cell_ctrl_t                   ctrl;
    point_t                       new_pt;
    wave_t                        launch;
    point_t                       pts  [MAX_POINTS];
    wave_t                        waves[MAX_POINTS];
    wave_t                        wave_end;
    logic                         root_done;
    logic                         root_busy;
    logic [ROOT_BITS-1:0]         root_val;

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign room         = (n_reg < CNT_BITS'(MAX_POINTS));
    assign result_valid = (state_reg == ST_DONE);
    assign result       = result_reg;

    // shift in new points at the head; clear the whole chain after a result
    assign ctrl.shift = accept && room;
    assign ctrl.clear = (state_reg == ST_DONE);
    assign new_pt     = '{valid: 1'b1, x: in_word.point_x, y: in_word.point_y};

    assign launch = '{valid: launch_reg, first: first_reg, bx: bx_reg, by: by_reg,
                      found: 1'b0, dmin: '0, mx: '0, my: '0};
    assign wave_end = waves[MAX_POINTS-1];

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            emst_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .pt_in    (new_pt),
                .pt_out   (pts[i]),
                .wave_in  (launch),
                .wave_out (waves[i])
            );
        end
        else
        begin : g_body
            emst_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .pt_in    (pts[i-1]),
                .pt_out   (pts[i]),
                .wave_in  (waves[i-1]),
                .wave_out (waves[i])
            );
        end
    end

    emst_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go_reg),
        .d2    (d2_reg),
        .done  (root_done),
        .busy  (root_busy),
        .root  (root_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            n_reg      <= '0;
            ovf_reg    <= 1'b0;
            launch_reg <= 1'b0;
            first_reg  <= 1'b0;
            go_reg     <= 1'b0;
        end
        else
        begin
            launch_reg <= 1'b0;
            go_reg     <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (room)
                        begin
                            n_reg  <= n_reg + 1'b1;
                            lx_reg <= in_word.point_x;
                            ly_reg <= in_word.point_y;
                        end
                        else
                            ovf_reg <= 1'b1;
                        if (in_word.last_point)
                        begin
                            // seed the tree with the newest stored point
                            state_reg  <= ST_WAVE;
                            launch_reg <= 1'b1;
                            first_reg  <= 1'b1;
                            bx_reg     <= room ? in_word.point_x : lx_reg;
                            by_reg     <= room ? in_word.point_y : ly_reg;
                            acc_reg    <= '0;
                        end
                    end
                end
                ST_WAVE:
                begin
                    if (wave_end.valid)
                    begin
                        if (wave_end.found)
                        begin
                            // nearest outside point joins the tree
                            state_reg <= ST_ROOT;
                            go_reg    <= 1'b1;
                            d2_reg    <= wave_end.dmin;
                            bx_reg    <= wave_end.mx;
                            by_reg    <= wave_end.my;
                        end
                        else
                        begin
                            state_reg                 <= ST_DONE;
                            result_reg.total_length   <= acc_reg;
                            result_reg.points_used    <= USED_BITS'(n_reg);
                            result_reg.points_dropped <= ovf_reg;
                        end
                    end
                end
                ST_ROOT:
                begin
                    if (root_done)
                    begin
                        acc_reg    <= acc_reg + TOTAL_BITS'(root_val);
                        state_reg  <= ST_WAVE;
                        launch_reg <= 1'b1;
                        first_reg  <= 1'b0;
                    end
                end
                ST_DONE:
                begin
                    // drop the loaded set
                    state_reg <= ST_IDLE;
                    n_reg     <= '0;
                    ovf_reg   <= 1'b0;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    idle_chain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !wave_end.valid)
        else $error("sweep reached chain end while idle");
    root_only_in_root_state: assert property (@(posedge clk) disable iff (!rst_n)
        root_busy |-> (state_reg == ST_ROOT))
        else $error("root unit running outside root state");
    result_has_points: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (n_reg != '0))
        else $error("result with an empty point set");
    launch_only_from_wave: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> (state_reg == ST_WAVE))
        else $error("sweep launched outside wave state");

endmodule
